@@ hw/rtl/skf_pkg.sv @@
// shared constants and types for the scalar kalman filter unit
package skf_pkg;

    localparam int CHANNELS   = 4;
    localparam int CH_IDX_W   = $clog2(CHANNELS);
    localparam int CHAN_W     = 2;
    localparam int SAMPLE_W   = 16;
    localparam int VALUE_W    = 32;
    localparam int GAIN_W     = 17;
    localparam int FRAC_W     = 16;
    localparam int DIV_STEPS  = GAIN_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int MUL_A_W    = VALUE_W + 1;
    localparam int MUL_B_W    = GAIN_W + 1;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int CFG_IDX_W  = 8;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 56;

    localparam logic [VALUE_W-1:0]   PROCESS_NOISE_RST     = 32'd1311;
    localparam logic [VALUE_W-1:0]   MEASUREMENT_NOISE_RST = 32'd458752;
    localparam logic [GAIN_W-1:0]    GAIN_ONE              = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 8'd1;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_LOAD    = 8'b0000_0010,
        ST_DIV     = 8'b0000_0100,
        ST_MUL_EST = 8'b0000_1000,
        ST_UPD_EST = 8'b0001_0000,
        ST_MUL_COV = 8'b0010_0000,
        ST_UPD_COV = 8'b0100_0000,
        ST_DONE    = 8'b1000_0000
    } t_state;

endpackage

@@ hw/rtl/scalar_kalman_filter_unit.sv @@
// scalar kalman filter unit: per-channel estimate and covariance update
// steps: load, 17 divide steps through one restoring subtractor, two passes
// through one multiplier, then the result moves to the output register
// a new transaction is accepted only in idle, after the last one has finished all steps
// the next input is taken while a finished result waits on the output register
// reset: synchronous active low; estimates and covariances cleared to zero,
// noise registers to their defaults
module scalar_kalman_filter_unit
    import skf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [VALUE_W-1:0]    i_cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // sample[15:0]
    input  logic [CHAN_W-1:0]     s_tuser,   // channel[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // estimate[31:0], gain[48:32], zero pad
    output logic [CHAN_W-1:0]     m_tuser    // channel_out[1:0]
);

    t_state                      r_state, n_state;
    logic [CHAN_W-1:0]           r_ch, n_ch;
    logic signed [SAMPLE_W-1:0]  r_sample, n_sample;
    logic [VALUE_W-1:0]          r_pmid, n_pmid;
    logic [VALUE_W:0]            r_den, n_den;
    logic [VALUE_W+1:0]          r_rem, n_rem;
    logic [GAIN_W-1:0]           r_quo, n_quo;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic signed [VALUE_W-1:0]   r_est_old;
    logic signed [PROD_W-1:0]    r_prod, n_prod;
    logic [GAIN_W-1:0]           r_gain, n_gain;
    logic signed [VALUE_W-1:0]   r_est_new, n_est_new;

    logic                        r_m_valid, n_m_valid;
    logic [CHAN_W-1:0]           r_m_ch, n_m_ch;
    logic [VALUE_W-1:0]          r_m_est, n_m_est;
    logic [GAIN_W-1:0]           r_m_gain, n_m_gain;

    logic [VALUE_W-1:0]          r_q, r_r;
    logic signed [VALUE_W-1:0]   r_est_mem [CHANNELS];
    logic [VALUE_W-1:0]          r_cov_mem [CHANNELS];

    logic [CH_IDX_W-1:0]         ch_idx;
    logic                        ch_ok;
    logic [VALUE_W:0]            p_sum;
    logic [VALUE_W-1:0]          p_mid;
    logic [VALUE_W+1:0]          rem_sh, rem_sub;
    logic                        rem_ge;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]    mul_p;
    logic signed [VALUE_W:0]     diff;
    logic signed [PROD_W-1:0]    rnd;
    logic [GAIN_W-1:0]           one_minus;
    logic                        est_we, cov_we;

    assign ch_idx   = r_ch[CH_IDX_W-1:0];
    assign ch_ok    = int'(r_ch) < CHANNELS;
    assign p_sum    = {1'b0, r_cov_mem[ch_idx]} + {1'b0, r_q};
    assign p_mid    = p_sum[VALUE_W] ? '1 : p_sum[VALUE_W-1:0];
    assign rem_sh   = (r_cnt == '0) ? r_rem : {r_rem[VALUE_W:0], 1'b0};
    assign rem_ge   = rem_sh >= {1'b0, r_den};
    assign rem_sub  = rem_sh - {1'b0, r_den};
    assign diff     = {r_sample[SAMPLE_W-1], r_sample, {FRAC_W{1'b0}}}
                    - {r_est_old[VALUE_W-1], r_est_old};
    assign one_minus = GAIN_ONE - r_gain;
    assign mul_p    = mul_a * mul_b;
    assign rnd      = r_prod + PROD_W'(32768);

    always_comb begin
        if (r_state == ST_MUL_COV) begin
            mul_a = {1'b0, r_pmid};
            mul_b = {1'b0, one_minus};
        end else begin
            mul_a = diff;
            mul_b = {1'b0, r_gain};
        end
    end

    always_comb begin
        n_state   = r_state;
        n_ch      = r_ch;
        n_sample  = r_sample;
        n_pmid    = r_pmid;
        n_den     = r_den;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_cnt     = r_cnt;
        n_prod    = r_prod;
        n_gain    = r_gain;
        n_est_new = r_est_new;
        n_m_valid = r_m_valid;
        n_m_ch    = r_m_ch;
        n_m_est   = r_m_est;
        n_m_gain  = r_m_gain;
        est_we    = 1'b0;
        cov_we    = 1'b0;

        if (r_m_valid && m_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (s_tvalid) begin
                    n_ch     = s_tuser;
                    n_sample = s_tdata;
                    n_state  = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_pmid    = p_mid;
                n_den     = {1'b0, p_mid} + {1'b0, r_r};
                n_rem     = {2'b00, p_mid};
                n_quo     = '0;
                n_cnt     = '0;
                if (ch_ok) begin
                    n_state = ST_DIV;
                end else begin
                    n_gain    = '0;
                    n_est_new = '0;
                    n_state   = ST_DONE;
                end
            end
            ST_DIV: begin
                n_rem = rem_ge ? rem_sub : rem_sh;
                n_quo = {r_quo[GAIN_W-2:0], rem_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_gain  = (r_den == '0) ? '0 : {r_quo[GAIN_W-2:0], rem_ge};
                    n_state = ST_MUL_EST;
                end
            end
            ST_MUL_EST: begin
                n_prod  = mul_p;
                n_state = ST_UPD_EST;
            end
            ST_UPD_EST: begin
                n_est_new = r_est_old + rnd[FRAC_W+VALUE_W-1:FRAC_W];
                est_we    = 1'b1;
                n_state   = ST_MUL_COV;
            end
            ST_MUL_COV: begin
                n_prod  = mul_p;
                n_state = ST_UPD_COV;
            end
            ST_UPD_COV: begin
                cov_we  = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_m_valid || m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_ch    = r_ch;
                    n_m_est   = r_est_new;
                    n_m_gain  = r_gain;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch      <= n_ch;
        r_sample  <= n_sample;
        r_pmid    <= n_pmid;
        r_den     <= n_den;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_cnt     <= n_cnt;
        if (r_state == ST_LOAD) begin
            r_est_old <= r_est_mem[ch_idx];
        end
        r_prod    <= n_prod;
        r_gain    <= n_gain;
        r_est_new <= n_est_new;
        r_m_ch    <= n_m_ch;
        r_m_est   <= n_m_est;
        r_m_gain  <= n_m_gain;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= PROCESS_NOISE_RST;
            r_r <= MEASUREMENT_NOISE_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_PROCESS_NOISE) begin
                r_q <= i_cfg_data;
            end
            if (i_cfg_index == REG_MEASUREMENT_NOISE) begin
                r_r <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_est_mem[i] <= '0;
                r_cov_mem[i] <= '0;
            end
        end else begin
            if (est_we) begin
                r_est_mem[ch_idx] <= n_est_new;
            end
            if (cov_we) begin
                r_cov_mem[ch_idx] <= r_prod[FRAC_W+VALUE_W-1:FRAC_W];
            end
        end
    end

    assign o_cfg_ready = 1'b1;
    assign s_tready    = (r_state == ST_IDLE);
    assign m_tvalid    = r_m_valid;
    assign m_tuser     = r_m_ch;
    assign m_tdata     = {{(M_TDATA_W-VALUE_W-GAIN_W){1'b0}}, r_m_gain, r_m_est};

    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> (r_state == ST_LOAD))
        else $error("accepted transaction did not start a load");

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> (r_m_gain <= GAIN_ONE))
        else $error("gain above one");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_cnt < CNT_W'(DIV_STEPS)))
        else $error("divider step count out of range");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_cnt != '0) |-> (r_rem <= {1'b0, r_den}))
        else $error("divider remainder exceeds denominator");

endmodule

@@ tb/scalar_kalman_filter_unit_tb.sv @@
// self-checking testbench for the scalar kalman filter unit, with an in-bench filter predictor
module scalar_kalman_filter_unit_tb
    import skf_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 30;
    localparam int PRINT_CAP      = 100;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 70;
    localparam logic [CFG_IDX_W-1:0] BAD_INDEX_LOW  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] BAD_INDEX_HIGH = 8'hFF;
    localparam logic [VALUE_W-1:0]   NOISE_MAX      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [CHAN_W-1:0]         ch;
        logic signed [VALUE_W-1:0] estimate;
        logic [GAIN_W-1:0]         gain;
    } t_filter_result;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [VALUE_W-1:0]    i_cfg_data  = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata     = '0;
    logic [CHAN_W-1:0]     s_tuser     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [CHAN_W-1:0]     m_tuser;

    // filter state mirrored by the predictor
    logic signed [VALUE_W-1:0] est_q [CHANNELS];
    logic [VALUE_W-1:0]        cov_q [CHANNELS];
    logic [VALUE_W-1:0]        q_noise;
    logic [VALUE_W-1:0]        r_noise;

    t_filter_result pending_results [$];
    int  err_count   = 0;
    int  burst_left  = 0;
    int  idle_cycles = 0;
    int  truth [CHANNELS];
    logic [10:0] rx_cycle = '0;
    int  rx_hold = 0;

    scalar_kalman_filter_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (err_count < PRINT_CAP) begin
            $display("%0t ns: %s mismatch, got %0h expected %0h", $realtime, what, got, want);
        end
        err_count++;
    endtask

    function automatic void reset_filter_state();
        q_noise = PROCESS_NOISE_RST;
        r_noise = MEASUREMENT_NOISE_RST;
        for (int i = 0; i < CHANNELS; i++) begin
            est_q[i] = '0;
            cov_q[i] = '0;
        end
    endfunction

    function automatic void predict_filter_step(input logic [CHAN_W-1:0] ch,
                                                input logic [SAMPLE_W-1:0] smp);
        longint unsigned p_mid, den, gain;
        longint est, diff, est_new, gain_s;
        t_filter_result res;
        p_mid = cov_q[ch];
        p_mid = p_mid + q_noise;
        if (p_mid > 64'hFFFF_FFFF) begin
            p_mid = 64'hFFFF_FFFF;
        end
        den = p_mid + r_noise;
        gain = (den == 0) ? 64'd0 : (p_mid << FRAC_W) / den;
        est = est_q[ch];
        diff = longint'($signed(smp));
        diff = diff * 65536 - est;
        gain_s = longint'(gain);
        est_new = est + ((diff * gain_s + 32768) >>> FRAC_W);
        est_q[ch] = est_new[VALUE_W-1:0];
        cov_q[ch] = 32'((p_mid * (65536 - gain)) >> FRAC_W);
        res.ch = ch;
        res.estimate = est_new[VALUE_W-1:0];
        res.gain = gain[GAIN_W-1:0];
        pending_results.push_back(res);
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [VALUE_W-1:0] data, input bit last_write);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == REG_PROCESS_NOISE) begin
            q_noise = data;
        end else if (idx == REG_MEASUREMENT_NOISE) begin
            r_noise = data;
        end
        if (last_write) begin
            i_cfg_valid <= 1'b0;
        end
    endtask

    task automatic set_noise(input logic [VALUE_W-1:0] q, input logic [VALUE_W-1:0] r);
        write_register(REG_PROCESS_NOISE, q, 1'b0);
        write_register(REG_MEASUREMENT_NOISE, r, 1'b1);
    endtask

    task automatic send_sample(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= ch;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        predict_filter_step(ch, smp);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_noise();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return NOISE_MAX;
            2: return $urandom_range(0, 4096);
            3: return $urandom_range(0, 32'h0010_0000);
            4: return $urandom;
            default: return 32'h0000_0100 << $urandom_range(0, 23);
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(input int ch);
        int v;
        case ($urandom_range(0, 9))
            7: return SAMPLE_W'($urandom);
            8: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            9: begin
                truth[ch] = int'($urandom_range(0, 65535)) - 32768;
                return truth[ch][SAMPLE_W-1:0];
            end
            default: begin
                v = truth[ch] + int'($urandom_range(0, 1024)) - 512;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
                return v[SAMPLE_W-1:0];
            end
        endcase
    endfunction

    task automatic test_default_noise();
        send_sample(2'd0, 16'h7FFF);
        send_sample(2'd0, 16'h7FFF);
        send_sample(2'd1, 16'h8000);
        send_sample(2'd2, 16'h0000);
        send_sample(2'd3, 16'h0001);
        send_sample(2'd3, 16'hFFFF);
    endtask

    task automatic test_gain_extremes();
        // full gain, covariance saturating on channels that hold some
        wait_idle();
        set_noise(NOISE_MAX, '0);
        send_sample(2'd0, 16'h7FFF);
        send_sample(2'd1, 16'h8000);
        send_sample(2'd2, 16'h5555);
        send_sample(2'd3, 16'hAAAA);
        // zero covariance and zero noise give a zero denominator
        wait_idle();
        set_noise('0, '0);
        send_sample(2'd0, 16'h8000);
        send_sample(2'd1, 16'h7FFF);
        send_sample(2'd2, 16'hAAAA);
        send_sample(2'd3, 16'h5555);
        wait_idle();
        set_noise('0, NOISE_MAX);
        send_sample(2'd0, 16'h1234);
        send_sample(2'd1, 16'hEDCB);
        wait_idle();
        set_noise(NOISE_MAX, NOISE_MAX);
        send_sample(2'd0, 16'h8000);
        send_sample(2'd1, 16'h7FFF);
        send_sample(2'd2, 16'h8000);
        send_sample(2'd3, 16'h7FFF);
    endtask

    task automatic test_register_index_decode();
        wait_idle();
        set_noise(PROCESS_NOISE_RST, MEASUREMENT_NOISE_RST);
        write_register(BAD_INDEX_LOW, $urandom, 1'b0);
        write_register(BAD_INDEX_HIGH, $urandom, 1'b1);
        send_sample(2'd1, 16'h4000);
        send_sample(2'd2, 16'hC000);
    endtask

    task automatic test_random_tracking();
        logic [CHAN_W-1:0] ch;
        for (int i = 0; i < CHANNELS; i++) begin
            truth[i] = int'($urandom_range(0, 65535)) - 32768;
        end
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            if (p == 0) begin
                set_noise(PROCESS_NOISE_RST, MEASUREMENT_NOISE_RST);
            end else begin
                set_noise(pick_noise(), pick_noise());
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                ch = CHAN_W'($urandom_range(0, CHANNELS - 1));
                send_sample(ch, pick_sample(ch));
            end
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_filter_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", longint'(m_tdata), 0);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.ch) begin
                    report_mismatch("channel", m_tuser, want.ch);
                end
                if (m_tdata[VALUE_W-1:0] !== want.estimate) begin
                    report_mismatch("estimate", m_tdata[VALUE_W-1:0], want.estimate);
                end
                if (m_tdata[VALUE_W +: GAIN_W] !== want.gain) begin
                    report_mismatch("gain", m_tdata[VALUE_W +: GAIN_W], want.gain);
                end
            end
        end
    end

    // receiver stall pattern, with its style chosen by rx_cycle[10:9]
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1'b1;
        case (rx_cycle[10:9])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= 1'($urandom_range(0, 1));
            2'd2: m_tready <= (rx_cycle[2:0] == 3'd5);
            default: begin
                if (rx_hold == 0) begin
                    m_tready <= ~m_tready;
                    rx_hold <= $urandom_range(0, 40);
                end else begin
                    rx_hold <= rx_hold - 1;
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        reset_filter_state();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_noise();
        test_gain_extremes();
        test_register_index_decode();
        test_random_tracking();
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch("missing results", pending_results.size(), 0);
        end
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
